// ===== hdl/rrte_pkg.sv =====
package rrte_pkg;

    // Identifiers are carried at the widest supported width inside the block.
    localparam int ID_MAX_BITS   = 64;
    localparam int HANDLE_BITS   = 16;
    localparam int MODE_BITS     = 3;
    localparam int SLOT_BITS     = 6;
    localparam int KIND_BITS     = 3;
    localparam int COUNT_BITS    = 4;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = 2;
    localparam int QUEUE_DEPTH   = 2;

    localparam int FINGER_COUNT_DEF = 64;
    localparam int SUCC_MAX_DEF     = 8;
    localparam int ID_BITS_DEF      = 64;

    localparam logic [MODE_BITS-1:0] MODE_LOAD_FINGER = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_LOAD_SUCC   = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_LOOKUP      = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_NOTIFY      = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_DROP_PRED   = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_READ_PRED   = 3'd5;
    localparam logic [MODE_BITS-1:0] MODE_OFFER       = 3'd6;

    localparam logic [KIND_BITS-1:0] KIND_FOUND   = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_FORWARD = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_SELF    = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_PRED    = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_ACK     = 3'd4;

    localparam logic [CFG_IDX_BITS-1:0] REG_SELF_ID     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SELF_HANDLE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SUCC_IN_USE = 2'd2;

    typedef logic [ID_MAX_BITS-1:0] id_t;
    typedef logic [HANDLE_BITS-1:0] handle_t;

    typedef enum logic [2:0] {
        OP_LOAD_FINGER,
        OP_LOAD_SUCC,
        OP_LOOKUP,
        OP_NOTIFY,
        OP_DROP_PRED,
        OP_READ_PRED,
        OP_OFFER,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                  op;
        id_t                  key;
        handle_t              node_handle;
        logic [SLOT_BITS-1:0] slot;
    } item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FINGER_SCAN,
        ST_SUCC_SCAN
    } state_t;

    // True when x lies in the open ring interval (a, b); equal ends mean
    // the whole ring except that end.
    function automatic logic in_open(id_t x, id_t a, id_t b);
        logic r;
        if (a == b)
        begin
            r = (x != a);
        end
        else if (a < b)
        begin
            r = (x > a) && (x < b);
        end
        else
        begin
            r = (x > a) || (x < b);
        end
        return r;
    endfunction

endpackage

// ===== hdl/rrte_ram.sv =====
module rrte_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rrte_front.sv =====
module rrte_front #(
    parameter int FINGER_COUNT = rrte_pkg::FINGER_COUNT_DEF,
    parameter int SUCC_MAX     = rrte_pkg::SUCC_MAX_DEF,
    parameter int ID_BITS      = rrte_pkg::ID_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [rrte_pkg::MODE_BITS-1:0]   mode,
    input  logic [ID_BITS-1:0]               node_key,
    input  logic [rrte_pkg::HANDLE_BITS-1:0] node_handle,
    input  logic [rrte_pkg::SLOT_BITS-1:0]   slot,
    output logic                             q_valid,
    output rrte_pkg::item_t                  q_item,
    input  logic                             q_pop
);

    localparam int CW = $clog2(rrte_pkg::QUEUE_DEPTH + 1);

    rrte_pkg::item_t q_reg [rrte_pkg::QUEUE_DEPTH];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    rrte_pkg::item_t new_item;
    logic            push;

    // Decode the mode; a load to a slot beyond the table becomes a no-op and writes nothing.
    always_comb
    begin
        new_item.key         = rrte_pkg::ID_MAX_BITS'(node_key);
        new_item.node_handle = node_handle;
        new_item.slot        = slot;
        case (mode)
            rrte_pkg::MODE_LOAD_FINGER:
                new_item.op = (32'(slot) < FINGER_COUNT) ? rrte_pkg::OP_LOAD_FINGER
                                                         : rrte_pkg::OP_NOP;
            rrte_pkg::MODE_LOAD_SUCC:
                new_item.op = (32'(slot) < SUCC_MAX) ? rrte_pkg::OP_LOAD_SUCC
                                                     : rrte_pkg::OP_NOP;
            rrte_pkg::MODE_LOOKUP:    new_item.op = rrte_pkg::OP_LOOKUP;
            rrte_pkg::MODE_NOTIFY:    new_item.op = rrte_pkg::OP_NOTIFY;
            rrte_pkg::MODE_DROP_PRED: new_item.op = rrte_pkg::OP_DROP_PRED;
            rrte_pkg::MODE_READ_PRED: new_item.op = rrte_pkg::OP_READ_PRED;
            rrte_pkg::MODE_OFFER:     new_item.op = rrte_pkg::OP_OFFER;
            default:                  new_item.op = rrte_pkg::OP_NOP;
        endcase
    end

    assign in_stall = (count_reg == CW'(rrte_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== hdl/rrte_back.sv =====
module rrte_back #(
    parameter int FINGER_COUNT = rrte_pkg::FINGER_COUNT_DEF,
    parameter int SUCC_MAX     = rrte_pkg::SUCC_MAX_DEF,
    parameter int ID_BITS      = rrte_pkg::ID_BITS_DEF,
    parameter int SW           = (SUCC_MAX > 1) ? $clog2(SUCC_MAX) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  rrte_pkg::item_t                q_item,
    output logic                           q_pop,
    input  rrte_pkg::id_t                  self_id,
    input  rrte_pkg::handle_t              self_handle,
    input  logic [SW-1:0]                  succ_last,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic [rrte_pkg::KIND_BITS-1:0] out_kind,
    output rrte_pkg::id_t                  out_id,
    output rrte_pkg::handle_t              out_handle
);

    localparam int FW = (FINGER_COUNT > 1) ? $clog2(FINGER_COUNT) : 1;
    localparam int RW = ID_BITS + rrte_pkg::HANDLE_BITS;

    rrte_pkg::state_t  state_reg, state_next;
    logic [FW-1:0]     cidx_reg, cidx_next;
    logic [SW-1:0]     sidx_reg, sidx_next;
    rrte_pkg::id_t     key_reg, key_next;

    rrte_pkg::id_t     succ_id_reg [SUCC_MAX];
    rrte_pkg::handle_t succ_handle_reg [SUCC_MAX];
    rrte_pkg::id_t     pred_id_reg;
    rrte_pkg::handle_t pred_handle_reg;
    logic              pred_valid_reg;

    logic                           out_valid_reg;
    logic [rrte_pkg::KIND_BITS-1:0] out_kind_reg;
    rrte_pkg::id_t                  out_id_reg;
    rrte_pkg::handle_t              out_handle_reg;

    logic              ram_we;
    logic [FW-1:0]     ram_raddr;
    logic [RW-1:0]     ram_rdata;
    rrte_pkg::id_t     fid;
    rrte_pkg::handle_t fhandle;

    logic                           res_load;
    logic [rrte_pkg::KIND_BITS-1:0] res_kind;
    rrte_pkg::id_t                  res_id;
    rrte_pkg::handle_t              res_handle;
    logic                           pred_set, pred_clr, succ_wr, offer;
    logic                           out_free;

    rrte_ram #(
        .WIDTH (RW),
        .DEPTH (FINGER_COUNT),
        .AW    (FW)
    ) u_finger_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_item.slot[FW-1:0]),
        .wdata ({q_item.key[ID_BITS-1:0], q_item.node_handle}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign fid      = rrte_pkg::ID_MAX_BITS'(ram_rdata[RW-1:rrte_pkg::HANDLE_BITS]);
    assign fhandle  = ram_rdata[rrte_pkg::HANDLE_BITS-1:0];
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cidx_next  = cidx_reg;
        sidx_next  = sidx_reg;
        key_next   = key_reg;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_raddr  = cidx_reg - FW'(1);
        res_load   = 1'b0;
        res_kind   = rrte_pkg::KIND_ACK;
        res_id     = '0;
        res_handle = '0;
        pred_set   = 1'b0;
        pred_clr   = 1'b0;
        succ_wr    = 1'b0;
        offer      = 1'b0;
        case (state_reg)
            rrte_pkg::ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop    = 1'b1;
                    res_load = 1'b1;
                    case (q_item.op)
                        rrte_pkg::OP_LOAD_FINGER: ram_we  = 1'b1;
                        rrte_pkg::OP_LOAD_SUCC:   succ_wr = 1'b1;
                        rrte_pkg::OP_LOOKUP:
                        begin
                            if (rrte_pkg::in_open(q_item.key, self_id, succ_id_reg[0]) ||
                                q_item.key == succ_id_reg[0])
                            begin
                                res_kind   = rrte_pkg::KIND_FOUND;
                                res_id     = succ_id_reg[0];
                                res_handle = succ_handle_reg[0];
                            end
                            else
                            begin
                                res_load   = 1'b0;
                                key_next   = q_item.key;
                                cidx_next  = FW'(FINGER_COUNT - 1);
                                ram_raddr  = FW'(FINGER_COUNT - 1);
                                state_next = rrte_pkg::ST_FINGER_SCAN;
                            end
                        end
                        rrte_pkg::OP_NOTIFY:
                            pred_set = !pred_valid_reg ||
                                       rrte_pkg::in_open(q_item.key, pred_id_reg, self_id);
                        rrte_pkg::OP_DROP_PRED: pred_clr = 1'b1;
                        rrte_pkg::OP_READ_PRED:
                        begin
                            if (pred_valid_reg)
                            begin
                                res_kind   = rrte_pkg::KIND_PRED;
                                res_id     = pred_id_reg;
                                res_handle = pred_handle_reg;
                            end
                        end
                        rrte_pkg::OP_OFFER:
                            offer = rrte_pkg::in_open(q_item.key, self_id, succ_id_reg[0]);
                        default: ;
                    endcase
                end
            end
            rrte_pkg::ST_FINGER_SCAN:
            begin
                if (rrte_pkg::in_open(fid, self_id, key_reg))
                begin
                    res_load   = 1'b1;
                    state_next = rrte_pkg::ST_IDLE;
                    if (fhandle == self_handle)
                    begin
                        res_kind   = rrte_pkg::KIND_SELF;
                        res_id     = self_id;
                        res_handle = self_handle;
                    end
                    else
                    begin
                        res_kind   = rrte_pkg::KIND_FORWARD;
                        res_id     = fid;
                        res_handle = fhandle;
                    end
                end
                else if (cidx_reg == '0)
                begin
                    sidx_next  = '0;
                    state_next = rrte_pkg::ST_SUCC_SCAN;
                end
                else
                begin
                    cidx_next = cidx_reg - FW'(1);
                end
            end
            rrte_pkg::ST_SUCC_SCAN:
            begin
                if (rrte_pkg::in_open(succ_id_reg[sidx_reg], self_id, key_reg) &&
                    succ_handle_reg[sidx_reg] != self_handle)
                begin
                    res_load   = 1'b1;
                    state_next = rrte_pkg::ST_IDLE;
                    res_kind   = rrte_pkg::KIND_FORWARD;
                    res_id     = succ_id_reg[sidx_reg];
                    res_handle = succ_handle_reg[sidx_reg];
                end
                else if (rrte_pkg::in_open(succ_id_reg[sidx_reg], self_id, key_reg) ||
                         sidx_reg == succ_last)
                begin
                    res_load   = 1'b1;
                    state_next = rrte_pkg::ST_IDLE;
                    res_kind   = rrte_pkg::KIND_SELF;
                    res_id     = self_id;
                    res_handle = self_handle;
                end
                else
                begin
                    sidx_next = sidx_reg + SW'(1);
                end
            end
            default: state_next = rrte_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rrte_pkg::ST_IDLE;
            out_valid_reg   <= 1'b0;
            pred_valid_reg  <= 1'b0;
            pred_id_reg     <= '0;
            pred_handle_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pred_set)
            begin
                pred_valid_reg  <= 1'b1;
                pred_id_reg     <= q_item.key;
                pred_handle_reg <= q_item.node_handle;
            end
            else if (pred_clr)
            begin
                pred_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cidx_reg <= cidx_next;
        sidx_reg <= sidx_next;
        key_reg  <= key_next;
        if (res_load)
        begin
            out_kind_reg   <= res_kind;
            out_id_reg     <= res_id;
            out_handle_reg <= res_handle;
        end
        if (succ_wr)
        begin
            succ_id_reg[q_item.slot[SW-1:0]]     <= q_item.key;
            succ_handle_reg[q_item.slot[SW-1:0]] <= q_item.node_handle;
        end
        else if (offer)
        begin
            for (int i = 1; i < SUCC_MAX; i++)
            begin
                if (SW'(i) <= succ_last)
                begin
                    succ_id_reg[i]     <= succ_id_reg[i-1];
                    succ_handle_reg[i] <= succ_handle_reg[i-1];
                end
            end
            succ_id_reg[0]     <= q_item.key;
            succ_handle_reg[0] <= q_item.node_handle;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_id     = out_id_reg;
    assign out_handle = out_handle_reg;

endmodule

// ===== hdl/ring_routing_table_engine.sv =====
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  mode, node_key, node_handle, slot
// result    out        out_valid/out_stall  answer_kind, answer_id, answer_handle
// config    in         cfg_we               cfg_index, cfg_data
//
// Loads, notify, predecessor drop, predecessor read and successor offers are
// done by the execution unit in its idle state, as is a lookup answered by the
// first successor; any other lookup scans the finger memory one entry a cycle
// from the top, then the successor list one entry a cycle. The finger memory's
// single read port sets the scan rate. A two-word queue sits ahead of the
// execution unit, and a result register behind it, so the input side keeps
// taking words while a result waits, until the queue is full. Reset clears
// control state, the own identifier and handle and the predecessor, and sets
// the successor count to one; the tables need no clearing.
module ring_routing_table_engine #(
    parameter int FINGER_COUNT = rrte_pkg::FINGER_COUNT_DEF,
    parameter int SUCC_MAX     = rrte_pkg::SUCC_MAX_DEF,
    parameter int ID_BITS      = rrte_pkg::ID_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [rrte_pkg::MODE_BITS-1:0]       mode,
    input  logic [ID_BITS-1:0]                   node_key,
    input  logic [rrte_pkg::HANDLE_BITS-1:0]     node_handle,
    input  logic [rrte_pkg::SLOT_BITS-1:0]       slot,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [rrte_pkg::KIND_BITS-1:0]       answer_kind,
    output logic [ID_BITS-1:0]                   answer_id,
    output logic [rrte_pkg::HANDLE_BITS-1:0]     answer_handle,
    input  logic                                 cfg_we,
    input  logic [rrte_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [rrte_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int SW = (SUCC_MAX > 1) ? $clog2(SUCC_MAX) : 1;

    // Configuration registers.
    logic [ID_BITS-1:0]                 self_id_reg;
    rrte_pkg::handle_t                  self_handle_reg;
    logic [rrte_pkg::COUNT_BITS-1:0]    succ_cnt_reg;
    logic [SW-1:0]                      succ_last;

    logic            q_valid;
    rrte_pkg::item_t q_item;
    logic            q_pop;
    rrte_pkg::id_t   out_id;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg     <= '0;
            self_handle_reg <= '0;
            succ_cnt_reg    <= rrte_pkg::COUNT_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rrte_pkg::REG_SELF_ID:     self_id_reg     <= cfg_data[ID_BITS-1:0];
                rrte_pkg::REG_SELF_HANDLE: self_handle_reg <= cfg_data[rrte_pkg::HANDLE_BITS-1:0];
                rrte_pkg::REG_SUCC_IN_USE: succ_cnt_reg    <= cfg_data[rrte_pkg::COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Index of the last successor entry in use: a count of zero acts as one,
    // and a count beyond the list acts as the full list.
    always_comb
    begin
        if (succ_cnt_reg == '0)
        begin
            succ_last = '0;
        end
        else if (32'(succ_cnt_reg) > SUCC_MAX)
        begin
            succ_last = SW'(SUCC_MAX - 1);
        end
        else
        begin
            succ_last = SW'(succ_cnt_reg - rrte_pkg::COUNT_BITS'(1));
        end
    end

    rrte_front #(
        .FINGER_COUNT (FINGER_COUNT),
        .SUCC_MAX     (SUCC_MAX),
        .ID_BITS      (ID_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .node_key    (node_key),
        .node_handle (node_handle),
        .slot        (slot),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    rrte_back #(
        .FINGER_COUNT (FINGER_COUNT),
        .SUCC_MAX     (SUCC_MAX),
        .ID_BITS      (ID_BITS),
        .SW           (SW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .self_id     (rrte_pkg::ID_MAX_BITS'(self_id_reg)),
        .self_handle (self_handle_reg),
        .succ_last   (succ_last),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_kind    (answer_kind),
        .out_id      (out_id),
        .out_handle  (answer_handle)
    );

    assign answer_id = out_id[ID_BITS-1:0];

endmodule
